/* sv/cliff_avoid_motor_sequencer_unit_macros.svh */
// Assertion macros shared by the checker.
`ifndef CLIFF_AVOID_MOTOR_SEQUENCER_UNIT_MACROS_SVH
`define CLIFF_AVOID_MOTOR_SEQUENCER_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CAMSEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CAMSEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/camseq_pkg.sv */
`timescale 1ns / 1ps
package camseq_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'hFC;
    localparam logic [7:0] TRL_BYTE  = 8'hFD;
    localparam logic [7:0] MAG_CAP   = 8'd150;
    localparam logic [3:0] SCORE_CAP = 4'd10;
    localparam logic [3:0] SCORE_TRIP = 4'd2;
    localparam logic [5:0] MAX_TRIES = 6'd40;
    localparam logic [1:0] SAFE_NEEDED = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKUP_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_TICKS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SPEED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_SPEED    = 3'd7;

    // register reset values
    localparam logic [15:0] RST_STARTUP_TICKS = 16'd200;
    localparam logic [15:0] RST_POLL_TICKS    = 16'd2;
    localparam logic [15:0] RST_BACKUP_TICKS  = 16'd100;
    localparam logic [15:0] RST_CHECK_TICKS   = 16'd5;
    localparam logic [15:0] RST_TURN_TICKS    = 16'd100;
    localparam logic [7:0]  RST_FORWARD_SPEED = 8'd30;
    localparam logic [7:0]  RST_REVERSE_SPEED = 8'd80;
    localparam logic [7:0]  RST_SPIN_SPEED    = 8'd80;

    // byte positions within a frame
    localparam logic [2:0] POS_LDIR    = 3'd1;
    localparam logic [2:0] POS_LMAG    = 3'd2;
    localparam logic [2:0] POS_RDIR    = 3'd3;
    localparam logic [2:0] POS_RMAG    = 3'd4;
    localparam logic [2:0] POS_TRAILER = 3'd5;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_RUN,
        PH_CHECK
    } phase_t;

    // one motor command, magnitudes already capped
    typedef struct packed {
        logic       lrev;
        logic [7:0] lmag;
        logic       rrev;
        logic [7:0] rmag;
    } cmd_t;

    function automatic logic [7:0] cap_mag(input logic [7:0] s);
        return (s > MAG_CAP) ? MAG_CAP : s;
    endfunction

    function automatic cmd_t make_cmd(input logic [7:0] lspd, input logic lrev,
                                      input logic [7:0] rspd, input logic rrev);
        cmd_t c;
        c.lmag = cap_mag(lspd);
        c.rmag = cap_mag(rspd);
        c.lrev = lrev && (c.lmag != 8'd0);
        c.rrev = rrev && (c.rmag != 8'd0);
        return c;
    endfunction

endpackage

/* sv/camseq_front.sv */
`timescale 1ns / 1ps
module camseq_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_left_danger,
    input  logic                                s_right_danger,
    input  logic                                cfg_we,
    input  logic [camseq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [camseq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                q_full,
    output logic                                q_push,
    output camseq_pkg::cmd_t                    q_cmd
);

    logic [15:0] startup_ticks_reg, poll_ticks_reg, backup_ticks_reg;
    logic [15:0] check_ticks_reg, turn_ticks_reg;
    logic [7:0]  forward_speed_reg, reverse_speed_reg, spin_speed_reg;

    camseq_pkg::phase_t phase_reg, phase_next;
    logic [15:0] tick_timer_reg, tick_timer_next;
    logic [3:0]  edge_score_reg, edge_score_next;
    logic [1:0]  safe_run_reg, safe_run_next;
    logic [5:0]  recheck_count_reg, recheck_count_next;
    logic        latched_left_reg, latched_left_next;

    logic        accept;
    logic        danger;
    logic [3:0]  score_up;
    logic [3:0]  score_new;
    logic [1:0]  safe_inc;
    logic        do_turn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_ticks_reg <= camseq_pkg::RST_STARTUP_TICKS;
            poll_ticks_reg    <= camseq_pkg::RST_POLL_TICKS;
            backup_ticks_reg  <= camseq_pkg::RST_BACKUP_TICKS;
            check_ticks_reg   <= camseq_pkg::RST_CHECK_TICKS;
            turn_ticks_reg    <= camseq_pkg::RST_TURN_TICKS;
            forward_speed_reg <= camseq_pkg::RST_FORWARD_SPEED;
            reverse_speed_reg <= camseq_pkg::RST_REVERSE_SPEED;
            spin_speed_reg    <= camseq_pkg::RST_SPIN_SPEED;
        end else if (cfg_we) begin
            case (cfg_index)
                camseq_pkg::REG_STARTUP_TICKS: startup_ticks_reg <= cfg_wdata;
                camseq_pkg::REG_POLL_TICKS:    poll_ticks_reg    <= cfg_wdata;
                camseq_pkg::REG_BACKUP_TICKS:  backup_ticks_reg  <= cfg_wdata;
                camseq_pkg::REG_CHECK_TICKS:   check_ticks_reg   <= cfg_wdata;
                camseq_pkg::REG_TURN_TICKS:    turn_ticks_reg    <= cfg_wdata;
                camseq_pkg::REG_FORWARD_SPEED: forward_speed_reg <= cfg_wdata[7:0];
                camseq_pkg::REG_REVERSE_SPEED: reverse_speed_reg <= cfg_wdata[7:0];
                camseq_pkg::REG_SPIN_SPEED:    spin_speed_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= camseq_pkg::PH_INIT;
            tick_timer_reg    <= '0;
            edge_score_reg    <= '0;
            safe_run_reg      <= '0;
            recheck_count_reg <= '0;
            latched_left_reg  <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            tick_timer_reg    <= tick_timer_next;
            edge_score_reg    <= edge_score_next;
            safe_run_reg      <= safe_run_next;
            recheck_count_reg <= recheck_count_next;
            latched_left_reg  <= latched_left_next;
        end
    end

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign danger   = s_left_danger || s_right_danger;
    assign score_up = edge_score_reg + 4'd2;
    assign safe_inc = safe_run_reg + 2'd1;

    always_comb begin
        phase_next         = phase_reg;
        tick_timer_next    = tick_timer_reg;
        edge_score_next    = edge_score_reg;
        safe_run_next      = safe_run_reg;
        recheck_count_next = recheck_count_reg;
        latched_left_next  = latched_left_reg;
        q_push             = 1'b0;
        q_cmd              = '0;
        do_turn            = 1'b0;
        score_new          = edge_score_reg;

        if (accept) begin
            if (phase_reg == camseq_pkg::PH_INIT) begin
                // initial stop frame, then wait out start-up
                phase_next      = camseq_pkg::PH_RUN;
                tick_timer_next = startup_ticks_reg;
                q_push          = 1'b1;
                q_cmd           = camseq_pkg::make_cmd(8'd0, 1'b0, 8'd0, 1'b0);
            end else if (tick_timer_reg > 16'd1) begin
                tick_timer_next = tick_timer_reg - 16'd1;
            end else begin
                tick_timer_next = '0;
                if (phase_reg == camseq_pkg::PH_CHECK) begin
                    if (recheck_count_reg >= camseq_pkg::MAX_TRIES) begin
                        do_turn = 1'b1;
                    end else begin
                        recheck_count_next = recheck_count_reg + 6'd1;
                        if (!danger) begin
                            safe_run_next = safe_inc;
                            if (safe_inc >= camseq_pkg::SAFE_NEEDED) begin
                                do_turn = 1'b1;
                            end else begin
                                tick_timer_next = check_ticks_reg;
                            end
                        end else begin
                            safe_run_next   = '0;
                            tick_timer_next = check_ticks_reg;
                        end
                    end
                end else begin
                    // edge poll through the weighted filter
                    latched_left_next = s_left_danger;
                    if (danger) begin
                        score_new = (score_up > camseq_pkg::SCORE_CAP) ?
                                    camseq_pkg::SCORE_CAP : score_up;
                    end else if (edge_score_reg != 4'd0) begin
                        score_new = edge_score_reg - 4'd1;
                    end
                    phase_next = camseq_pkg::PH_RUN;
                    q_push     = 1'b1;
                    if (score_new >= camseq_pkg::SCORE_TRIP) begin
                        edge_score_next    = '0;
                        safe_run_next      = '0;
                        recheck_count_next = '0;
                        phase_next         = camseq_pkg::PH_CHECK;
                        tick_timer_next    = backup_ticks_reg;
                        q_cmd = camseq_pkg::make_cmd(reverse_speed_reg, 1'b1,
                                                     reverse_speed_reg, 1'b1);
                    end else begin
                        edge_score_next = score_new;
                        tick_timer_next = poll_ticks_reg;
                        q_cmd = camseq_pkg::make_cmd(forward_speed_reg, 1'b0,
                                                     forward_speed_reg, 1'b0);
                    end
                end
            end

            if (do_turn) begin
                // turn away from the side latched at the last poll
                phase_next      = camseq_pkg::PH_RUN;
                tick_timer_next = turn_ticks_reg;
                q_push          = 1'b1;
                q_cmd = camseq_pkg::make_cmd(spin_speed_reg, !latched_left_reg,
                                             spin_speed_reg, latched_left_reg);
            end
        end
    end

endmodule

/* sv/camseq_queue.sv */
`timescale 1ns / 1ps
module camseq_queue #(
    parameter int DEPTH = camseq_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  camseq_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output camseq_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    camseq_pkg::cmd_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* sv/camseq_back.sv */
`timescale 1ns / 1ps
module camseq_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  camseq_pkg::cmd_t q_cmd,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_frame_byte,
    output logic             m_frame_last
);

    camseq_pkg::cmd_t cmd_reg, cmd_next;
    logic [2:0]       pos_reg, pos_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             valid_reg, valid_next;
    logic [7:0]       sel_byte;
    logic             load;

    always_comb begin
        case (pos_reg)
            camseq_pkg::POS_LDIR:    sel_byte = {7'd0, cmd_reg.lrev};
            camseq_pkg::POS_LMAG:    sel_byte = cmd_reg.lmag;
            camseq_pkg::POS_RDIR:    sel_byte = {7'd0, cmd_reg.rrev};
            camseq_pkg::POS_RMAG:    sel_byte = cmd_reg.rmag;
            camseq_pkg::POS_TRAILER: sel_byte = camseq_pkg::TRL_BYTE;
            default:                 sel_byte = camseq_pkg::HDR_BYTE;
        endcase
    end

    // take the next command once the current frame is gone or leaving
    assign load  = q_valid && (!valid_reg || (m_ready && last_reg));
    assign q_pop = load;

    always_comb begin
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        if (load) begin
            cmd_next   = q_cmd;
            byte_next  = camseq_pkg::HDR_BYTE;
            last_next  = 1'b0;
            pos_next   = camseq_pkg::POS_LDIR;
            valid_next = 1'b1;
        end else if (valid_reg && m_ready) begin
            if (last_reg) begin
                valid_next = 1'b0;
                last_next  = 1'b0;
            end else begin
                byte_next = sel_byte;
                last_next = (pos_reg == camseq_pkg::POS_TRAILER);
                pos_next  = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            pos_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        byte_reg <= byte_next;
    end

    assign m_valid      = valid_reg;
    assign m_frame_byte = byte_reg;
    assign m_frame_last = last_reg;

endmodule

/* sv/cliff_avoid_motor_sequencer_unit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// s_ tick   in   s_valid/s_ready    s_left_danger, s_right_danger
// m_ frame  out  m_valid/m_ready    m_frame_byte[7:0], m_frame_last
// cfg       in   cfg_we             cfg_index[2:0], cfg_wdata[15:0]
//
// Each tick item is decided in the front in the cycle it is accepted; ready
// stays high as long as the command queue has room.
// A command leaves as a 6-byte frame, one byte per cycle while m_ready is high,
// so the output side (byte counter in the back) sets the rate for commanding
// ticks; a tick that only counts down sends no frame.
// Reset (synchronous, aresetn low) loads register defaults and the initial
// stop-pending phase; there is no clearing pass.
// An output stall holds the current byte; the queue keeps the front running
// until QUEUE_DEPTH commands are waiting.
module cliff_avoid_motor_sequencer_unit #(
    parameter int QUEUE_DEPTH = camseq_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_left_danger,
    input  logic                              s_right_danger,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_frame_byte,
    output logic                              m_frame_last,
    input  logic                              cfg_we,
    input  logic [camseq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [camseq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // front to queue
    logic             q_full;
    logic             q_push;
    camseq_pkg::cmd_t q_push_cmd;

    // queue to back
    logic             q_not_empty;
    logic             q_pop;
    camseq_pkg::cmd_t q_head_cmd;

    // Classify each tick: initial stop, count down, poll the edge filter, re-check, or turn.
    camseq_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_danger  (s_left_danger),
        .s_right_danger (s_right_danger),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_push_cmd)
    );

    // Hold pending motor commands so a stalled frame does not stop the ticks.
    camseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head_cmd)
    );

    // Serialize each command into FC, dir, mag, dir, mag, FD.
    camseq_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_not_empty),
        .q_cmd        (q_head_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_last (m_frame_last)
    );

endmodule

/* sv/camseq_checker.sv */
`timescale 1ns / 1ps
`include "cliff_avoid_motor_sequencer_unit_macros.svh"
module camseq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_frame_byte,
    input logic       m_frame_last
);

    // no item on the output right after reset
    `CAMSEQ_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !m_valid, "m_valid after reset")

    // the last byte of every frame is the trailer
    `CAMSEQ_ASSERT(a_last_is_trailer, (m_valid && m_frame_last) |-> (m_frame_byte == camseq_pkg::TRL_BYTE), "frame_last without trailer")

    // a frame that follows a finished one opens with the header
    `CAMSEQ_ASSERT(a_next_is_header, (m_valid && m_ready && m_frame_last) |=> (!m_valid || m_frame_byte == camseq_pkg::HDR_BYTE), "frame without header")

    // a stalled byte holds
    `CAMSEQ_ASSERT(a_stall_holds, (m_valid && !m_ready) |=> (m_valid && $stable(m_frame_byte) && $stable(m_frame_last)), "stalled item changed")

endmodule

bind cliff_avoid_motor_sequencer_unit camseq_checker u_camseq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_byte (m_frame_byte),
    .m_frame_last (m_frame_last)
);
